FILE: sv/ehist_pkg.sv
package ehist_pkg;

   localparam int MAX_TIME_BINS = 64;
   localparam int MAX_VOLT_BINS = 64;
   localparam int COUNT_WIDTH = 32;

   localparam int CELLS = MAX_TIME_BINS * MAX_VOLT_BINS;
   localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

   localparam int UI_W = 9;
   localparam int UI_MAX = 256;
   localparam int PHASE_W = 8;
   localparam int NT_W = $clog2(MAX_TIME_BINS + 1);
   localparam int NV_W = $clog2(MAX_VOLT_BINS + 1);
   localparam int DVD_W = PHASE_W + NT_W;
   localparam int DCNT_W = $clog2(DVD_W + 1);
   localparam int VPROD_W = 40;
   localparam int CSR_ADDR_W = 5;

   typedef enum logic [2:0] {
      REG_UI_SAMPLES = 3'd0,
      REG_TIME_BIN_COUNT = 3'd1,
      REG_VOLT_BIN_COUNT = 3'd2,
      REG_WARMUP_INTERVALS = 3'd3,
      REG_V_LOW = 3'd4,
      REG_V_SCALE = 3'd5
   } reg_index_type;

   typedef enum logic {
      REQ_ADD = 1'b0,
      REQ_READ = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ_DATA,
      ST_DIVIDE,
      ST_FETCH,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic [8:0] ui_samples;
      logic [6:0] time_bin_count;
      logic [6:0] volt_bin_count;
      logic signed [15:0] v_low;
      logic [23:0] v_scale;
      logic warmup_load;
      logic [15:0] warmup_value;
   } cfg_type;

   typedef struct packed {
      logic done;
      logic [DVD_W-1:0] quotient;
   } div_status_type;

   // Counts wider than the result port saturate at its all-ones value.
   function automatic logic [31:0] to_out(logic [COUNT_WIDTH-1:0] c);
      logic [47:0] w;
      w = 48'(c);
      to_out = (w > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
   endfunction

endpackage

FILE: sv/eye_diagram_histogram.sv
// Eye-diagram histogram. Each add beat bins one waveform sample into a
// time-by-voltage grid held in a single-port-per-direction RAM and increments
// that cell with saturation; each read beat returns one cell's count and the
// running peak. After reset a clearing pass zeroes the RAM, one cell per
// cycle, over all MAX_TIME_BINS * MAX_VOLT_BINS cells while req_ready is low;
// register writes are taken during it. Items are handled one at a time: a
// read beat reads the RAM and then loads the output register, an add beat
// during warmup only advances the phase, and a counted add beat runs the
// bit-serial time-bin divider (one quotient bit per cycle over PHASE_W + NT_W
// bits), then the RAM read and write-back of the cell. A finished result sits
// in an output register; while it waits, the next beat is held off unless the
// result is taken in the same cycle.
module eye_diagram_histogram import ehist_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_type,
   input  logic signed [15:0]    req_sample,
   input  logic [5:0]            req_read_time_bin,
   input  logic [5:0]            req_read_volt_bin,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [31:0]           rsp_cell_count,
   output logic [31:0]           rsp_peak_count,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   cfg_type        cfg;
   div_status_type div_status;

   state_type state_ff, state_in;

   logic [ADDR_W-1:0]      clr_ff, clr_in;
   logic [PHASE_W-1:0]     phase_ff, phase_in;
   logic [15:0]            warm_ff, warm_in;
   logic [COUNT_WIDTH-1:0] peak_ff, peak_in;
   logic [15:0]            diff_mag_ff, diff_mag_in;
   logic                   diff_pos_ff, diff_pos_in;
   logic [VPROD_W-1:0]     prod_ff;
   logic [ADDR_W-1:0]      upd_addr_ff, upd_addr_in;
   logic                   oob_ff, oob_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [31:0]            rsp_cell_ff, rsp_cell_in;
   logic [31:0]            rsp_peak_ff, rsp_peak_in;

   logic                   accept, accept_add, accept_read, counting, div_start;
   logic [UI_W-1:0]        ui_eff;
   logic [NT_W-1:0]        nt_eff;
   logic [NV_W-1:0]        nv_eff;
   logic [PHASE_W-1:0]     p_eff;
   logic [UI_W-1:0]        p_next;
   logic                   wrap;
   logic [DVD_W-1:0]       dividend;
   logic signed [16:0]     diff;
   logic [23:0]            vq;
   logic [NV_W-1:0]        vb_sel;
   logic [DVD_W-1:0]       tb_sel;
   logic [ADDR_W-1:0]      calc_addr, rd_addr;
   logic                   rd_oob;

   logic                   ram_we;
   logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
   logic [COUNT_WIDTH-1:0] ram_wdata, ram_rdata, inc;

   ehist_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ehist_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (ui_eff),
      .status   (div_status)
   );

   ehist_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (CELLS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Effective grid settings with out-of-range register values clamped.
   always_comb begin
      if (cfg.ui_samples == '0) begin
         ui_eff = UI_W'(1);
      end else if (int'(cfg.ui_samples) > UI_MAX) begin
         ui_eff = UI_W'(UI_MAX);
      end else begin
         ui_eff = cfg.ui_samples;
      end
      if (cfg.time_bin_count == '0) begin
         nt_eff = NT_W'(1);
      end else if (int'(cfg.time_bin_count) > MAX_TIME_BINS) begin
         nt_eff = NT_W'(MAX_TIME_BINS);
      end else begin
         nt_eff = NT_W'(cfg.time_bin_count);
      end
      if (cfg.volt_bin_count == '0) begin
         nv_eff = NV_W'(1);
      end else if (int'(cfg.volt_bin_count) > MAX_VOLT_BINS) begin
         nv_eff = NV_W'(MAX_VOLT_BINS);
      end else begin
         nv_eff = NV_W'(cfg.volt_bin_count);
      end
   end

   assign accept = req_valid && req_ready;
   assign accept_add = accept && (req_type == REQ_ADD);
   assign accept_read = accept && (req_type == REQ_READ);
   assign counting = (warm_ff == '0);
   assign div_start = accept_add && counting;

   // A phase left beyond a lowered interval length counts as phase zero.
   assign p_eff = (UI_W'(phase_ff) >= ui_eff) ? '0 : phase_ff;
   assign p_next = UI_W'(p_eff) + 1'b1;
   assign wrap = (p_next >= ui_eff);
   assign dividend = DVD_W'(p_eff) * DVD_W'(nt_eff);
   assign diff = $signed({req_sample[15], req_sample}) - $signed({cfg.v_low[15], cfg.v_low});

   // Bin selection once the quotient and the voltage product are ready.
   always_comb begin
      vq = prod_ff[VPROD_W-1:16];
      if (!diff_pos_ff) begin
         vb_sel = '0;
      end else if (vq >= 24'(nv_eff)) begin
         vb_sel = NV_W'(nv_eff - 1'b1);
      end else begin
         vb_sel = NV_W'(vq);
      end
      if (div_status.quotient >= DVD_W'(nt_eff)) begin
         tb_sel = DVD_W'(nt_eff - 1'b1);
      end else begin
         tb_sel = div_status.quotient;
      end
      calc_addr = ADDR_W'(ADDR_W'(vb_sel) * ADDR_W'(MAX_TIME_BINS) + ADDR_W'(tb_sel));
      rd_oob = (int'(req_read_time_bin) >= MAX_TIME_BINS) ||
               (int'(req_read_volt_bin) >= MAX_VOLT_BINS);
      rd_addr = ADDR_W'(ADDR_W'(req_read_volt_bin) * ADDR_W'(MAX_TIME_BINS) +
                        ADDR_W'(req_read_time_bin));
   end

   assign inc = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == ADDR_W'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept_read) begin
               state_in = ST_READ_DATA;
            end else if (div_start) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_READ_DATA: state_in = ST_IDLE;
         ST_DIVIDE: begin
            if (div_status.done) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH:  state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // State outputs: handshake and RAM control.
   always_comb begin
      req_ready = 1'b0;
      ram_we = 1'b0;
      ram_waddr = upd_addr_ff;
      ram_wdata = inc;
      ram_raddr = upd_addr_ff;
      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
         end
         ST_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            ram_raddr = rd_addr;
         end
         ST_UPDATE: ram_we = 1'b1;
         default: ;
      endcase
   end

   // Datapath registers.
   always_comb begin
      clr_in = clr_ff;
      phase_in = phase_ff;
      warm_in = warm_ff;
      peak_in = peak_ff;
      diff_mag_in = diff_mag_ff;
      diff_pos_in = diff_pos_ff;
      upd_addr_in = upd_addr_ff;
      oob_in = oob_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_cell_in = rsp_cell_ff;
      rsp_peak_in = rsp_peak_ff;

      if (state_ff == ST_CLEAR) begin
         clr_in = clr_ff + 1'b1;
      end
      if (accept_add) begin
         diff_mag_in = diff[15:0];
         diff_pos_in = !diff[16] && (diff != '0);
         if (wrap) begin
            phase_in = '0;
            if (warm_ff != '0) begin
               warm_in = warm_ff - 1'b1;
            end
         end else begin
            phase_in = p_next[PHASE_W-1:0];
         end
      end
      if (cfg.warmup_load) begin
         warm_in = cfg.warmup_value;
      end
      if (accept_read) begin
         oob_in = rd_oob;
      end
      if (state_ff == ST_DIVIDE && div_status.done) begin
         upd_addr_in = calc_addr;
      end
      if (state_ff == ST_UPDATE && inc > peak_ff) begin
         peak_in = inc;
      end
      if (state_ff == ST_READ_DATA) begin
         rsp_valid_in = 1'b1;
         rsp_cell_in = oob_ff ? '0 : to_out(ram_rdata);
         rsp_peak_in = to_out(peak_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         phase_ff <= '0;
         warm_ff <= '0;
         peak_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         phase_ff <= phase_in;
         warm_ff <= warm_in;
         peak_ff <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      diff_mag_ff <= diff_mag_in;
      diff_pos_ff <= diff_pos_in;
      prod_ff <= VPROD_W'(diff_mag_ff) * VPROD_W'(cfg.v_scale);
      upd_addr_ff <= upd_addr_in;
      oob_ff <= oob_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_peak_ff <= rsp_peak_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cell_count = rsp_cell_ff;
   assign rsp_peak_count = rsp_peak_ff;

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ready)
      else $error("request taken during the clearing pass");

   a_peak_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (peak_ff >= $past(peak_ff)))
      else $error("peak count went down");

   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_READ_DATA))
      else $error("result raised outside a read");

   a_fetch_after_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |-> $past(div_status.done))
      else $error("cell fetched before the time bin was ready");

endmodule

FILE: sv/ehist_ram.sv
module ehist_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/ehist_div.sv
module ehist_div import ehist_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DVD_W-1:0]     dividend,
   input  logic [UI_W-1:0]      divisor,
   output div_status_type       status
);

   logic [UI_W-1:0]   rem_ff, rem_in;
   logic [UI_W-1:0]   dsr_ff, dsr_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [UI_W:0]     trial;

   // Restoring division, one quotient bit per cycle, MSB first.
   always_comb begin
      trial = {rem_ff, quo_ff[DVD_W-1]};
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in = '0;
         dsr_in = divisor;
         quo_in = dividend;
         cnt_in = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = UI_W'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[UI_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DCNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign status.done = done_ff;
   assign status.quotient = quo_ff;

endmodule

FILE: sv/ehist_csr.sv
module ehist_csr import ehist_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [8:0]  ui_ff, ui_in;
   logic [6:0]  ntb_ff, ntb_in;
   logic [6:0]  nvb_ff, nvb_in;
   logic [15:0] warm_ff, warm_in;
   logic [15:0] vlow_ff, vlow_in;
   logic [23:0] vscale_ff, vscale_in;
   logic        wr;
   reg_index_type idx;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign idx = reg_index_type'(csr_paddr[4:2]);

   always_comb begin
      ui_in = ui_ff;
      ntb_in = ntb_ff;
      nvb_in = nvb_ff;
      warm_in = warm_ff;
      vlow_in = vlow_ff;
      vscale_in = vscale_ff;
      if (wr) begin
         case (idx)
            REG_UI_SAMPLES:       ui_in = csr_pwdata[8:0];
            REG_TIME_BIN_COUNT:   ntb_in = csr_pwdata[6:0];
            REG_VOLT_BIN_COUNT:   nvb_in = csr_pwdata[6:0];
            REG_WARMUP_INTERVALS: warm_in = csr_pwdata[15:0];
            REG_V_LOW:            vlow_in = csr_pwdata[15:0];
            REG_V_SCALE:          vscale_in = csr_pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_UI_SAMPLES:       csr_prdata = 32'(ui_ff);
         REG_TIME_BIN_COUNT:   csr_prdata = 32'(ntb_ff);
         REG_VOLT_BIN_COUNT:   csr_prdata = 32'(nvb_ff);
         REG_WARMUP_INTERVALS: csr_prdata = 32'(warm_ff);
         REG_V_LOW:            csr_prdata = {{16{vlow_ff[15]}}, vlow_ff};
         REG_V_SCALE:          csr_prdata = 32'(vscale_ff);
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ui_ff <= 9'd16;
         ntb_ff <= 7'd16;
         nvb_ff <= 7'd16;
         warm_ff <= 16'd0;
         vlow_ff <= 16'hF000;
         vscale_ff <= 24'h080000;
      end else begin
         ui_ff <= ui_in;
         ntb_ff <= ntb_in;
         nvb_ff <= nvb_in;
         warm_ff <= warm_in;
         vlow_ff <= vlow_in;
         vscale_ff <= vscale_in;
      end
   end

   assign cfg.ui_samples = ui_ff;
   assign cfg.time_bin_count = ntb_ff;
   assign cfg.volt_bin_count = nvb_ff;
   assign cfg.v_low = $signed(vlow_ff);
   assign cfg.v_scale = vscale_ff;
   // The remaining-warmup counter reloads on the same edge as the register.
   assign cfg.warmup_load = wr && (idx == REG_WARMUP_INTERVALS);
   assign cfg.warmup_value = csr_pwdata[15:0];

endmodule

FILE: tb/sv/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ehist_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      logic [31:0] count;
      logic [31:0] peak;
   } cell_reading_type;

   typedef struct {
      req_kind_type kind;
      logic [15:0]  sample;
      logic [5:0]   tbin;
      logic [5:0]   vbin;
      bit           known;
      logic [31:0]  count;
      logic [31:0]  peak;
   } probe_row_type;

   typedef struct {
      int unsigned ui;
      int unsigned nt;
      int unsigned nv;
      int unsigned warm;
      int          vlow;
      int unsigned vscale;
      int          items;
      bit          idle;
      bit          hold;
   } grid_setup_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_type = 1'b0;
   logic signed [15:0]    req_sample = '0;
   logic [5:0]            req_read_time_bin = '0;
   logic [5:0]            req_read_volt_bin = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [31:0]           rsp_cell_count;
   logic [31:0]           rsp_peak_count;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // Predicted state of the histogram.
   logic [8:0]             mdl_ui;
   logic [6:0]             mdl_nt;
   logic [6:0]             mdl_nv;
   logic [15:0]            mdl_warm_left;
   logic signed [15:0]     mdl_v_low;
   logic [23:0]            mdl_v_scale;
   logic [7:0]             mdl_phase;
   logic [COUNT_WIDTH-1:0] grid_count [CELLS];
   logic [COUNT_WIDTH-1:0] grid_peak;

   cell_reading_type reads_due [$];
   cell_reading_type due;
   int            failures = 0;
   int unsigned   cycle_count = 0;
   bit            req_idle_on = 1'b1;
   bit            rsp_idle_on = 1'b1;
   bit            hold_rsp = 1'b0;
   int            read_pct = 35;

   probe_row_type probes [17] = '{
      '{REQ_READ, 16'h0000, 6'd0,  6'd0,  1'b1, 32'd0, 32'd0},
      '{REQ_READ, 16'hFFFF, 6'd63, 6'd63, 1'b1, 32'd0, 32'd0},
      '{REQ_ADD,  16'h8000, 6'd0,  6'd0,  1'b0, 32'd0, 32'd0},
      '{REQ_ADD,  16'h7FFF, 6'd0,  6'd0,  1'b0, 32'd0, 32'd0},
      '{REQ_ADD,  16'hF000, 6'd0,  6'd0,  1'b0, 32'd0, 32'd0},
      '{REQ_ADD,  16'hF001, 6'd0,  6'd0,  1'b0, 32'd0, 32'd0},
      '{REQ_ADD,  16'hF002, 6'd0,  6'd0,  1'b0, 32'd0, 32'd0},
      '{REQ_ADD,  16'h5555, 6'd0,  6'd0,  1'b0, 32'd0, 32'd0},
      '{REQ_ADD,  16'hAAAA, 6'd0,  6'd0,  1'b0, 32'd0, 32'd0},
      '{REQ_ADD,  16'h0000, 6'd0,  6'd0,  1'b0, 32'd0, 32'd0},
      '{REQ_READ, 16'h0000, 6'd0,  6'd0,  1'b0, 32'd0, 32'd0},
      '{REQ_READ, 16'h0000, 6'd1,  6'd15, 1'b0, 32'd0, 32'd0},
      '{REQ_READ, 16'h0000, 6'd3,  6'd8,  1'b0, 32'd0, 32'd0},
      '{REQ_READ, 16'h0000, 6'h15, 6'h2A, 1'b0, 32'd0, 32'd0},
      '{REQ_READ, 16'h0000, 6'h2A, 6'h15, 1'b0, 32'd0, 32'd0},
      '{REQ_READ, 16'h0000, 6'd63, 6'd0,  1'b0, 32'd0, 32'd0},
      '{REQ_READ, 16'h0000, 6'd0,  6'd63, 1'b0, 32'd0, 32'd0}
   };

   // The third row lowers the interval length below the phase left by the
   // second; the sixth holds every sample in warmup.
   grid_setup_type setups [10] = '{
      '{  8,   8,   8,     1,  -8192,     131072, 28, 1'b1, 1'b0},
      '{256,  64,  64,     0, -32768,   16777215, 28, 1'b1, 1'b0},
      '{  3,   1,   1,     0,  32767,          0, 28, 1'b0, 1'b0},
      '{  0,   0,   0,     3,      0,     262144, 28, 1'b1, 1'b0},
      '{511, 127, 127,     0,  -4096,     524288, 28, 1'b1, 1'b0},
      '{100,  64,  64, 65535,  -2048,      65536, 28, 1'b1, 1'b0},
      '{ 10,   7,  13,     0, -12000,     200000, 40, 1'b0, 1'b1},
      '{  1,  64,  32,     0, -16384,       8192, 28, 1'b1, 1'b0},
      '{200,  33,  50,     0,  -6000,       2000, 28, 1'b0, 1'b0},
      '{  5,   5,  40,     2,  -3000,       5000, 28, 1'b1, 1'b0}
   };

   eye_diagram_histogram DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_sample        (req_sample),
      .req_read_time_bin (req_read_time_bin),
      .req_read_volt_bin (req_read_volt_bin),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_cell_count    (rsp_cell_count),
      .rsp_peak_count    (rsp_peak_count),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic int unsigned clamp_u(int unsigned v, int unsigned lo,
                                           int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void grid_reset();
      mdl_ui = 9'd16;
      mdl_nt = 7'd16;
      mdl_nv = 7'd16;
      mdl_warm_left = '0;
      mdl_v_low = -16'sd4096;
      mdl_v_scale = 24'd524288;
      mdl_phase = '0;
      for (int i = 0; i < CELLS; i++) grid_count[i] = '0;
      grid_peak = '0;
   endfunction

   function automatic void bin_sample(logic signed [15:0] smp);
      int unsigned     ui;
      int unsigned     nt;
      int unsigned     nv;
      int unsigned     p;
      int unsigned     nxt;
      int unsigned     tb;
      int unsigned     vb;
      int unsigned     addr;
      int              diff;
      longint unsigned prod;
      ui = clamp_u(mdl_ui, 1, 256);
      nt = clamp_u(mdl_nt, 1, MAX_TIME_BINS);
      nv = clamp_u(mdl_nv, 1, MAX_VOLT_BINS);
      p = mdl_phase;
      // A phase left over from a longer interval restarts at zero.
      if (p >= ui) p = 0;
      if (mdl_warm_left == 0) begin
         diff = int'(smp) - int'(mdl_v_low);
         tb = (p * nt) / ui;
         if (tb >= nt) tb = nt - 1;
         if (diff <= 0) begin
            vb = 0;
         end else begin
            prod = (64'(diff) * 64'(mdl_v_scale)) >> 16;
            vb = (prod >= 64'(nv)) ? nv - 1 : int'(prod);
         end
         addr = vb * MAX_TIME_BINS + tb;
         if (grid_count[addr] != {COUNT_WIDTH{1'b1}}) grid_count[addr]++;
         if (grid_count[addr] > grid_peak) grid_peak = grid_count[addr];
      end
      nxt = p + 1;
      if (nxt >= ui) begin
         nxt = 0;
         if (mdl_warm_left != 0) mdl_warm_left--;
      end
      mdl_phase = nxt[7:0];
   endfunction

   function automatic cell_reading_type lookup_cell(logic [5:0] tbin, logic [5:0] vbin);
      cell_reading_type r;
      r.count = grid_count[int'(vbin) * MAX_TIME_BINS + int'(tbin)];
      r.peak = grid_peak;
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (reads_due.size() == 0) begin
            $error("cell_count: no read outstanding, actual %0d", rsp_cell_count);
            failures++;
         end else begin
            due = reads_due.pop_front();
            if (rsp_cell_count !== due.count) begin
               $error("cell_count: expected %0d, actual %0d", due.count, rsp_cell_count);
               failures++;
            end
            if (rsp_peak_count !== due.peak) begin
               $error("peak_count: expected %0d, actual %0d", due.peak, rsp_peak_count);
               failures++;
            end
         end
      end
   end

   // Result side: a drawn stall before each beat, and one long hold-off when
   // asked for so that the block backs up into its input.
   initial begin
      int stall;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = rsp_idle_on ? $urandom_range(0, 16) : 0;
         if (hold_rsp) begin
            stall = stall + HOLD_CYCLES;
            hold_rsp = 1'b0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         @(negedge clock);
         if ($urandom_range(0, 19) == 0) rsp_idle_on = !rsp_idle_on;
      end
   end

   // Called at a falling edge; returns at the falling edge after the beat.
   task automatic send_item(input req_kind_type kind, input logic [15:0] smp,
                            input logic [5:0] tbin, input logic [5:0] vbin,
                            input bit known, input logic [31:0] k_cell,
                            input logic [31:0] k_peak);
      int               gap;
      cell_reading_type r;
      gap = req_idle_on ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_sample <= smp;
      req_read_time_bin <= tbin;
      req_read_volt_bin <= vbin;
      do @(posedge clock); while (req_ready !== 1'b1);
      if (kind == REQ_READ) begin
         if (known) begin
            r.count = k_cell;
            r.peak = k_peak;
         end else begin
            r = lookup_cell(tbin, vbin);
         end
         reads_due = {reads_due, r};
      end else begin
         bin_sample(smp);
      end
      @(negedge clock);
   endtask

   task automatic random_item();
      int unsigned nt;
      int unsigned nv;
      int unsigned span;
      int          s;
      logic [5:0]  tb;
      logic [5:0]  vb;
      nt = clamp_u(mdl_nt, 1, MAX_TIME_BINS);
      nv = clamp_u(mdl_nv, 1, MAX_VOLT_BINS);
      if ($urandom_range(0, 99) < read_pct) begin
         if ($urandom_range(0, 3) == 0) begin
            tb = 6'($urandom);
            vb = 6'($urandom);
         end else begin
            tb = 6'($urandom_range(0, nt - 1));
            vb = 6'($urandom_range(0, nv - 1));
         end
         send_item(REQ_READ, 16'($urandom), tb, vb, 1'b0, '0, '0);
      end else begin
         if ($urandom_range(0, 2) == 0) begin
            s = int'($signed(16'($urandom)));
         end else begin
            // Aim at the span of sample values that lands inside the grid.
            span = (mdl_v_scale == 0) ? 65535 : (nv * 65536) / mdl_v_scale + 2;
            if (span > 65535) span = 65535;
            s = int'(mdl_v_low) - 1 + int'($urandom_range(0, span));
            if (s > 32767) s = 32767;
            if (s < -32768) s = -32768;
         end
         send_item(REQ_ADD, 16'(s), 6'($urandom), 6'($urandom), 1'b0, '0, '0);
      end
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [31:0] val);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      case (idx)
         REG_UI_SAMPLES:       mdl_ui = val[8:0];
         REG_TIME_BIN_COUNT:   mdl_nt = val[6:0];
         REG_VOLT_BIN_COUNT:   mdl_nv = val[6:0];
         REG_WARMUP_INTERVALS: mdl_warm_left = val[15:0];
         REG_V_LOW:            mdl_v_low = val[15:0];
         REG_V_SCALE:          mdl_v_scale = val[23:0];
         default: ;
      endcase
   endtask

   task automatic load_setup(input grid_setup_type g);
      csr_write(REG_UI_SAMPLES, g.ui);
      csr_write(REG_TIME_BIN_COUNT, g.nt);
      csr_write(REG_VOLT_BIN_COUNT, g.nv);
      csr_write(REG_WARMUP_INTERVALS, g.warm);
      csr_write(REG_V_LOW, 32'(g.vlow));
      csr_write(REG_V_SCALE, g.vscale);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Adds leave no result behind, so let the last of them finish as well.
   task automatic wait_drained();
      while (reads_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(input grid_setup_type g);
      load_setup(g);
      req_idle_on = g.idle;
      read_pct = g.hold ? 80 : 35;
      hold_rsp = g.hold;
      repeat (g.items) random_item();
      req_valid <= 1'b0;
      wait_drained();
   endtask

   initial begin
      grid_setup_type g;
      grid_reset();
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Directed rows run on the reset settings, first while the store clears.
      foreach (probes[i]) begin
         send_item(probes[i].kind, probes[i].sample, probes[i].tbin, probes[i].vbin,
                   probes[i].known, probes[i].count, probes[i].peak);
      end
      req_valid <= 1'b0;
      wait_drained();

      foreach (setups[i]) run_phase(setups[i]);

      repeat (4) begin
         g.ui = $urandom_range(0, 300);
         g.nt = $urandom_range(0, 70);
         g.nv = $urandom_range(0, 70);
         g.warm = $urandom_range(0, 3);
         g.vlow = int'($signed(16'($urandom)));
         g.vscale = $urandom_range(0, 1 << 20);
         g.items = 36;
         g.idle = $urandom_range(0, 1);
         g.hold = 1'b0;
         run_phase(g);
      end

      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: eye_diagram_histogram.f
sv/ehist_pkg.sv
sv/ehist_ram.sv
sv/ehist_div.sv
sv/ehist_csr.sv
sv/eye_diagram_histogram.sv
tb/sv/tb.sv
